>>> hdl/page_polarity_normalizer_defines.svh
// Assertion macros for the checker of the page polarity normaliser.
`ifndef PAGE_POLARITY_NORMALIZER_DEFINES_SVH
`define PAGE_POLARITY_NORMALIZER_DEFINES_SVH

// Clocked assertion that is switched off while reset is applied.
`define PPN_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define PPN_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/ppn_pkg.sv
// Shared types and constants for the page polarity normaliser.
`default_nettype none

package ppn_pkg;

  // Frame geometry.
  localparam int MAX_PIXELS = 65536;
  localparam int ADDR_W     = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int CNT_W      = $clog2(MAX_PIXELS + 1);
  localparam int PIX_W      = 8;
  localparam int SUM_W      = CNT_W + PIX_W;

  // Stretch divider sizing: numerator is off*510 + d, divisor 2d.
  localparam int STRETCH_K  = 510;
  localparam int DIV_NUM_W  = 17;
  localparam int DIV_DEN_W  = PIX_W + 1;
  localparam int STEP_W     = $clog2(PIX_W);

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PIXELS);
  localparam logic [PIX_W-1:0] PIX_MAX = {PIX_W{1'b1}};

  // Input command codes.
  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_FINISH = 2'd1,
    CMD_FETCH  = 2'd2
  } cmd_t;

  // Transform modes.
  typedef enum logic [1:0] {
    MODE_INV     = 2'd0,
    MODE_STRETCH = 2'd1,
    MODE_BIN     = 2'd2,
    MODE_PASS    = 2'd3
  } mode_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_DIVW,
    ST_EMIT,
    ST_SC_RD,
    ST_SC_GO,
    ST_SC_WAIT
  } state_t;

  // Request to the stretch divider.
  typedef struct packed {
    logic             start;
    logic [PIX_W-1:0] off;
    logic [PIX_W-1:0] rng;
  } div_req_t;

  // One result word.
  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             last;
    logic             inv;
    logic             err;
    logic             ovf;
  } result_t;

endpackage

`default_nettype wire

>>> hdl/ppn_ram.sv
// Simple dual-port frame store with registered read data.
`default_nettype none

module ppn_ram #(
  parameter int AW = 16,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, with registered read data.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> hdl/ppn_div.sv
// Restoring divider for the contrast stretch, one quotient bit per cycle.
`default_nettype none

module ppn_div import ppn_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  div_req_t         req,
  output logic             done,
  output logic [PIX_W-1:0] quo
);

  logic [DIV_NUM_W-1:0] rem_r, rem_nxt;
  logic [DIV_DEN_W-1:0] den_r, den_nxt;
  logic [PIX_W-1:0]     quo_r, quo_nxt;
  logic [STEP_W-1:0]    step_r, step_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_NUM_W-1:0] num_c;
  logic [DIV_NUM_W-1:0] trial_c;

  // Numerator off*510 + d; the quotient is known to stay below 256.
  assign num_c   = DIV_NUM_W'(req.off) * DIV_NUM_W'(STRETCH_K) + DIV_NUM_W'(req.rng);
  assign trial_c = DIV_NUM_W'(den_r) << step_r;

  // Next state: load on start, then one subtract-and-compare per cycle.
  always_comb begin
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = num_c;
      den_nxt  = {req.rng, 1'b0};
      quo_nxt  = '0;
      step_nxt = STEP_W'(PIX_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_r >= trial_c) begin
        rem_nxt         = rem_r - trial_c;
        quo_nxt[step_r] = 1'b1;
      end
      if (step_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        step_nxt = step_r - STEP_W'(1);
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    quo_r  <= quo_nxt;
    step_r <= step_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

`default_nettype wire

>>> hdl/page_polarity_normalizer.sv
// Top level of the page polarity normaliser: controller, statistics and output word.
//
// Usage: load words (cmd 0) write one gray pixel each into a 64K-entry frame
// store and update min, max, sum and nonzero count; loads beyond capacity are
// dropped and flagged. A finish word (cmd 1) fixes the mode from cfg_mode and
// decides the polarity. Fetch words (cmd 2) return one result word each on the
// out_ channel, in load order; a fetch with no finished frame or past the end
// returns a word with out_error set. A load after a finished frame starts anew.
// Loads, finishes in modes 0, 2 and 3, and ignored commands are done in ST_IDLE.
// A fetch goes through the memory read (ST_RD) and transform to ST_EMIT; in
// stretch mode the 8-step divider (ST_DIVW) sits between read and emit. A
// stretch finish walks the frame once through the same divider, with ST_SC_RD,
// ST_SC_GO and ST_SC_WAIT per pixel. in_stall is high while a word is at work.
// The output register holds a finished word while out_stall is high; the
// controller then waits with the next result. Reset (rst_n low, synchronous)
// clears the statistics, flags and mode; the store itself is not cleared.
`default_nettype none

module page_polarity_normalizer import ppn_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       in_cmd,
  input  logic [PIX_W-1:0] in_pixel_in,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [PIX_W-1:0] out_pixel_out,
  output logic             out_is_last,
  output logic             out_inverted,
  output logic             out_error,
  output logic             out_overflowed,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_mode
);

  state_t           state_r, state_nxt;
  mode_t            cfg_mode_r;
  mode_t            fmode_r, fmode_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] rp_r, rp_nxt;
  logic [PIX_W-1:0] min_r, min_nxt;
  logic [PIX_W-1:0] max_r, max_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0] nz_r, nz_nxt;
  logic             inv_r, inv_nxt;
  logic             ready_r, ready_nxt;
  logic             ovf_r, ovf_nxt;
  logic [SUM_W-1:0] acc_r, acc_nxt;
  result_t          res_r, res_nxt;
  result_t          out_r;
  logic             out_valid_r;
  logic             out_free;
  logic             out_load;

  // Load path values, with the frame already cleared when a finished one is restarted.
  logic [CNT_W-1:0] ld_cnt;
  logic [PIX_W-1:0] ld_min;
  logic [PIX_W-1:0] ld_max;
  logic [SUM_W-1:0] ld_sum;
  logic [CNT_W-1:0] ld_nz;

  logic [SUM_W-1:0] n128_c;
  logic [CNT_W-1:0] rp_inc_c;
  logic [PIX_W-1:0] rng_c;
  logic [PIX_W-1:0] diff_c;
  logic [PIX_W:0]   p2_c;
  logic [PIX_W:0]   mid2_c;
  logic             bin_zero_c;
  logic [SUM_W-1:0] acc_add_c;

  logic             ram_we;
  logic             ram_re;
  logic [PIX_W-1:0] ram_q;
  div_req_t         div_req;
  logic             div_done;
  logic [PIX_W-1:0] div_quo;

  ppn_ram #(
    .AW (ADDR_W),
    .DW (PIX_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ld_cnt[ADDR_W-1:0]),
    .wdata (in_pixel_in),
    .re    (ram_re),
    .raddr (rp_r[ADDR_W-1:0]),
    .rdata (ram_q)
  );

  ppn_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign ld_cnt = ready_r ? '0 : count_r;
  assign ld_min = ready_r ? PIX_MAX : min_r;
  assign ld_max = ready_r ? '0 : max_r;
  assign ld_sum = ready_r ? '0 : sum_r;
  assign ld_nz  = ready_r ? '0 : nz_r;

  // Brightness threshold 128*N and helper terms.
  assign n128_c    = {{(SUM_W - CNT_W - 7){1'b0}}, count_r, 7'b0};
  assign rp_inc_c  = rp_r + CNT_W'(1);
  assign diff_c    = max_r - min_r;
  assign rng_c     = (diff_c == '0) ? PIX_W'(1) : diff_c;
  assign p2_c      = {ram_q, 1'b0};
  assign mid2_c    = {1'b0, min_r} + {1'b0, max_r};
  assign bin_zero_c = inv_r ? (p2_c > mid2_c) : (p2_c < mid2_c);
  assign acc_add_c = acc_r + SUM_W'(div_quo);

  assign out_free = !out_valid_r || !out_stall;
  assign out_load = (state_r == ST_EMIT) && out_free;
  assign in_stall = (state_r != ST_IDLE);

  // Controller: next state, statistics and result word.
  always_comb begin
    state_nxt = state_r;
    fmode_nxt = fmode_r;
    count_nxt = count_r;
    rp_nxt    = rp_r;
    min_nxt   = min_r;
    max_nxt   = max_r;
    sum_nxt   = sum_r;
    nz_nxt    = nz_r;
    inv_nxt   = inv_r;
    ready_nxt = ready_r;
    ovf_nxt   = ovf_r;
    acc_nxt   = acc_r;
    res_nxt   = res_r;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    div_req   = '{start: 1'b0, off: ram_q - min_r, rng: rng_c};

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (in_cmd)
            CMD_LOAD: begin
              // A load after a finished frame starts a fresh one.
              if (ready_r) begin
                rp_nxt    = '0;
                inv_nxt   = 1'b0;
                ready_nxt = 1'b0;
                ovf_nxt   = 1'b0;
              end
              count_nxt = ld_cnt;
              min_nxt   = ld_min;
              max_nxt   = ld_max;
              sum_nxt   = ld_sum;
              nz_nxt    = ld_nz;
              if (ld_cnt == MAX_CNT) begin
                ovf_nxt = 1'b1;
              end else begin
                ram_we    = 1'b1;
                count_nxt = ld_cnt + CNT_W'(1);
                min_nxt   = (in_pixel_in < ld_min) ? in_pixel_in : ld_min;
                max_nxt   = (in_pixel_in > ld_max) ? in_pixel_in : ld_max;
                sum_nxt   = ld_sum + SUM_W'(in_pixel_in);
                nz_nxt    = (in_pixel_in != '0) ? ld_nz + CNT_W'(1) : ld_nz;
              end
            end
            CMD_FINISH: begin
              if (!ready_r && count_r != '0) begin
                fmode_nxt = cfg_mode_r;
                rp_nxt    = '0;
                unique case (cfg_mode_r)
                  MODE_INV: begin
                    inv_nxt   = (sum_r > n128_c);
                    ready_nxt = 1'b1;
                  end
                  MODE_STRETCH: begin
                    acc_nxt   = '0;
                    state_nxt = ST_SC_RD;
                  end
                  MODE_BIN: begin
                    inv_nxt   = (nz_r > (count_r >> 1));
                    ready_nxt = 1'b1;
                  end
                  MODE_PASS: begin
                    inv_nxt   = 1'b0;
                    ready_nxt = 1'b1;
                  end
                  default: ;
                endcase
              end
            end
            CMD_FETCH: begin
              if (!ready_r || rp_r >= count_r) begin
                res_nxt   = '{pix: '0, last: 1'b0, inv: 1'b0, err: 1'b1, ovf: ovf_r};
                state_nxt = ST_EMIT;
              end else begin
                ram_re       = 1'b1;
                res_nxt.last = (rp_inc_c == count_r);
                res_nxt.inv  = inv_r;
                res_nxt.err  = 1'b0;
                res_nxt.ovf  = ovf_r;
                rp_nxt       = rp_inc_c;
                state_nxt    = ST_RD;
              end
            end
            default: ;
          endcase
        end
      end
      ST_RD: begin
        // Stored pixel is now available; transform it by the frame's mode.
        state_nxt = ST_EMIT;
        unique case (fmode_r)
          MODE_INV:     res_nxt.pix = inv_r ? ~ram_q : ram_q;
          MODE_BIN:     res_nxt.pix = bin_zero_c ? '0 : PIX_MAX;
          MODE_PASS:    res_nxt.pix = ram_q;
          MODE_STRETCH: begin
            div_req.start = 1'b1;
            state_nxt     = ST_DIVW;
          end
          default: ;
        endcase
      end
      ST_DIVW: begin
        if (div_done) begin
          res_nxt.pix = inv_r ? ~div_quo : div_quo;
          state_nxt   = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SC_RD: begin
        ram_re    = 1'b1;
        state_nxt = ST_SC_GO;
      end
      ST_SC_GO: begin
        div_req.start = 1'b1;
        state_nxt     = ST_SC_WAIT;
      end
      ST_SC_WAIT: begin
        // Accumulate the stretched sum; decide polarity after the last pixel.
        if (div_done) begin
          acc_nxt = acc_add_c;
          if (rp_inc_c == count_r) begin
            inv_nxt   = (acc_add_c > n128_c);
            ready_nxt = 1'b1;
            rp_nxt    = '0;
            state_nxt = ST_IDLE;
          end else begin
            rp_nxt    = rp_inc_c;
            state_nxt = ST_SC_RD;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control and statistics registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cfg_mode_r  <= MODE_INV;
      fmode_r     <= MODE_INV;
      count_r     <= '0;
      rp_r        <= '0;
      min_r       <= PIX_MAX;
      max_r       <= '0;
      sum_r       <= '0;
      nz_r        <= '0;
      inv_r       <= 1'b0;
      ready_r     <= 1'b0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        cfg_mode_r <= mode_t'(cfg_mode);
      end
      fmode_r <= fmode_nxt;
      count_r <= count_nxt;
      rp_r    <= rp_nxt;
      min_r   <= min_nxt;
      max_r   <= max_nxt;
      sum_r   <= sum_nxt;
      nz_r    <= nz_nxt;
      inv_r   <= inv_nxt;
      ready_r <= ready_nxt;
      ovf_r   <= ovf_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    res_r <= res_nxt;
    if (out_load) begin
      out_r <= res_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pixel_out  = out_r.pix;
  assign out_is_last    = out_r.last;
  assign out_inverted   = out_r.inv;
  assign out_error      = out_r.err;
  assign out_overflowed = out_r.ovf;

endmodule

`default_nettype wire

>>> hdl/ppn_checker.sv
// Port-level checker for the page polarity normaliser, bound to the top level.
`default_nettype none
`include "page_polarity_normalizer_defines.svh"

module ppn_checker import ppn_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_stall,
  input logic [1:0]       in_cmd,
  input logic             out_valid,
  input logic             out_stall,
  input logic [PIX_W-1:0] out_pixel_out,
  input logic             out_is_last,
  input logic             out_inverted,
  input logic             out_error,
  input logic             out_overflowed
);

  logic [PIX_W+3:0] out_word;
  logic [PIX_W+1:0] err_payload;
  logic             fetch_acc;

  // Whole result word, the payload an error word must leave clear, and an accepted fetch.
  assign out_word    = {out_pixel_out, out_is_last, out_inverted, out_error, out_overflowed};
  assign err_payload = {out_pixel_out, out_is_last, out_inverted};
  assign fetch_acc   = in_valid && !in_stall && (in_cmd == CMD_FETCH);

  // A stalled result word stays valid and unchanged.
  `PPN_ASSERT_CLK(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_word), "stalled word changed")

  // An accepted fetch occupies the block for at least the memory read.
  `PPN_ASSERT_CLK(a_fetch_busy, fetch_acc |=> in_stall, "fetch accepted without stalling the input")

  // An error word carries no pixel, last or polarity information.
  `PPN_ASSERT_CLK(a_err_clean, out_valid && out_error |-> err_payload == '0, "error word carries payload")

  // Reset leaves the output empty and the input open.
  `PPN_ASSERT_RST(a_reset, !rst_n |=> !out_valid && !in_stall, "block not idle after reset")

endmodule

bind page_polarity_normalizer ppn_checker u_ppn_checker (.*);

`default_nettype wire
